@@ src/level_band_bit_frame_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Level band bit frame decoder - assertion macros
// Shared concurrent assertion helpers, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef LEVEL_BAND_BIT_FRAME_DECODER_UNIT_DEFINES_SVH
`define LEVEL_BAND_BIT_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define LBFD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbfd assertion failed");

// next-cycle implication
`define LBFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbfd assertion failed");

`endif

@@ src/lbfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfd_pkg
// Widths, register indexes, reset values and shared types of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbfd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SHIFT_W  = 10;
    localparam int COUNT_W  = 8;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 12;

    localparam logic [CIDX_W-1:0] REG_HIGH_BAND_LOWER = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HIGH_BAND_UPPER = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LOW_BAND_LOWER  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_LOW_BAND_UPPER  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FRAME_LIMIT     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_ACCEPT_LIMIT    = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_HIGH_BAND_LOWER = 12'd3750;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_BAND_UPPER = 12'd3850;
    localparam logic [SAMPLE_W-1:0] RST_LOW_BAND_LOWER  = 12'd150;
    localparam logic [SAMPLE_W-1:0] RST_LOW_BAND_UPPER  = 12'd250;
    localparam logic [SHIFT_W-1:0]  RST_FRAME_LIMIT     = 10'd512;
    localparam logic [SHIFT_W-1:0]  RST_ACCEPT_LIMIT    = 10'd840;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_band_lower;
        logic [SAMPLE_W-1:0] high_band_upper;
        logic [SAMPLE_W-1:0] low_band_lower;
        logic [SAMPLE_W-1:0] low_band_upper;
        logic [SHIFT_W-1:0]  frame_limit;
        logic [SHIFT_W-1:0]  accept_limit;
    } cfg_t;

    // per-channel action for one sample
    typedef struct packed {
        logic act;      // channel takes this sample
        logic bit_val;  // bit to shift in
        logic gate;     // count latch only above accept limit
    } ch_ctrl_t;

    typedef struct packed {
        ch_ctrl_t a;
        ch_ctrl_t b;
    } band_sel_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [SHIFT_W-1:0] code;
        logic [COUNT_W-1:0] count;
    } ch_state_t;

endpackage

@@ src/lbfd_if.sv @@
// ----------------------------------------------------------------------------
// lbfd interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbfd_sample_if
    import lbfd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lbfd_result_if
    import lbfd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_echo;
    logic [SHIFT_W-1:0]  last_code_a;
    logic [SHIFT_W-1:0]  last_code_b;
    logic [SHIFT_W-1:0]  shift_a;
    logic [SHIFT_W-1:0]  shift_b;
    logic [COUNT_W-1:0]  frames_a;
    logic [COUNT_W-1:0]  frames_b;

    modport source (output valid, output sample_echo, output last_code_a,
                    output last_code_b, output shift_a, output shift_b,
                    output frames_a, output frames_b, input ready);
    modport sink   (input valid, input sample_echo, input last_code_a,
                    input last_code_b, input shift_a, input shift_b,
                    input frames_a, input frames_b, output ready);
endinterface

interface lbfd_cfg_if
    import lbfd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/lbfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lbfd_cfg_regs
// Configuration register file; one write transaction per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbfd_cfg_regs
    import lbfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_index,
    input  logic [CDATA_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_band_lower <= RST_HIGH_BAND_LOWER;
            cfg_reg.high_band_upper <= RST_HIGH_BAND_UPPER;
            cfg_reg.low_band_lower  <= RST_LOW_BAND_LOWER;
            cfg_reg.low_band_upper  <= RST_LOW_BAND_UPPER;
            cfg_reg.frame_limit     <= RST_FRAME_LIMIT;
            cfg_reg.accept_limit    <= RST_ACCEPT_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HIGH_BAND_LOWER: cfg_reg.high_band_lower <= wr_data[SAMPLE_W-1:0];
                REG_HIGH_BAND_UPPER: cfg_reg.high_band_upper <= wr_data[SAMPLE_W-1:0];
                REG_LOW_BAND_LOWER:  cfg_reg.low_band_lower  <= wr_data[SAMPLE_W-1:0];
                REG_LOW_BAND_UPPER:  cfg_reg.low_band_upper  <= wr_data[SAMPLE_W-1:0];
                REG_FRAME_LIMIT:     cfg_reg.frame_limit     <= wr_data[SHIFT_W-1:0];
                REG_ACCEPT_LIMIT:    cfg_reg.accept_limit    <= wr_data[SHIFT_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/lbfd_band_decode.sv @@
// ----------------------------------------------------------------------------
// lbfd_band_decode
// Sorts a sample into level bands and picks the acting channel by priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbfd_band_decode
    import lbfd_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    input  logic                busy_a,
    input  logic                busy_b,
    output band_sel_t           sel
);

    logic one_a;
    logic one_b;
    logic zero_a;
    logic zero_b;

    // strict compares: a sample on a bound hits nothing
    assign one_a  = (sample < cfg.high_band_upper) && (sample > cfg.high_band_lower);
    assign one_b  = (sample > cfg.low_band_lower)  && (sample < cfg.low_band_upper);
    assign zero_a = (sample > cfg.high_band_upper) && busy_a;
    assign zero_b = (sample < cfg.low_band_lower)  && busy_b;

    always_comb
    begin
        sel.a.act     = one_a || (!one_b && zero_a);
        sel.a.bit_val = one_a;
        sel.a.gate    = 1'b0;
        sel.b.act     = !one_a && (one_b || (!zero_a && zero_b));
        sel.b.bit_val = one_b;
        sel.b.gate    = !one_b;
    end

endmodule

@@ src/lbfd_channel.sv @@
// ----------------------------------------------------------------------------
// lbfd_channel
// Shift register, latched code and frame counter of one channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbfd_channel
    import lbfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ch_ctrl_t           ctrl,
    input  logic [SHIFT_W-1:0] frame_limit,
    input  logic [SHIFT_W-1:0] accept_limit,
    output logic               busy,
    output ch_state_t          state
);

    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [SHIFT_W-1:0] code_reg,  code_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               act;
    logic               latch;

    assign act   = step && ctrl.act;
    assign latch = act && (shift_reg >= frame_limit);

    always_comb
    begin
        shift_next = shift_reg;
        code_next  = code_reg;
        count_next = count_reg;
        if (latch)
        begin
            shift_next = '0;
            code_next  = shift_reg;
            if (!ctrl.gate || (shift_reg > accept_limit))
                count_next = count_reg + COUNT_W'(1);
        end
        else if (act)
        begin
            shift_next = {shift_reg[SHIFT_W-2:0], ctrl.bit_val};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            code_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            code_reg  <= code_next;
            count_reg <= count_next;
        end
    end

    assign busy        = (shift_reg > SHIFT_W'(1));
    assign state.shift = shift_reg;
    assign state.code  = code_reg;
    assign state.count = count_reg;

endmodule

@@ src/level_band_bit_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// level_band_bit_frame_decoder_unit
// Level band classifier feeding two bit-frame shift channels.
// ----------------------------------------------------------------------------
// Pipeline: sample register, then channel and result registers; a result is
// registered when its sample moves on from the sample register.
// Throughput: one sample per cycle unless the result slot stalls; the band
// compares and one channel update sit between sample and channel/result registers.
// Input stays ready while no sample is held, the result slot is free or its result is taken.
// Reset: rst_n async, clears shifts, codes, counters and valids; registers
// return to their default bands and limits.
`timescale 1ns / 1ps

`include "level_band_bit_frame_decoder_unit_defines.svh"

module level_band_bit_frame_decoder_unit
    import lbfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    lbfd_sample_if.sink     samples,
    lbfd_result_if.source   results,
    lbfd_cfg_if.sink        cfg
);

    cfg_t                cfg_q;
    band_sel_t           sel;
    ch_state_t           st_a;
    ch_state_t           st_b;
    logic                busy_a;
    logic                busy_b;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] echo_reg;
    logic                adv;

    // a held sample moves on once the result slot is free or being drained
    assign adv           = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || adv;
    assign cfg.ready     = 1'b1;

    lbfd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    lbfd_band_decode u_decode (
        .sample (sample_reg),
        .cfg    (cfg_q),
        .busy_a (busy_a),
        .busy_b (busy_b),
        .sel    (sel)
    );

    lbfd_channel u_ch_a (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (adv),
        .ctrl         (sel.a),
        .frame_limit  (cfg_q.frame_limit),
        .accept_limit (cfg_q.accept_limit),
        .busy         (busy_a),
        .state        (st_a)
    );

    lbfd_channel u_ch_b (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (adv),
        .ctrl         (sel.b),
        .frame_limit  (cfg_q.frame_limit),
        .accept_limit (cfg_q.accept_limit),
        .busy         (busy_b),
        .state        (st_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
                in_valid_reg <= samples.valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            sample_reg <= samples.sample;
        if (adv)
            echo_reg <= sample_reg;
    end

    // channel state only changes on a step, so it doubles as the result payload
    assign results.valid       = out_valid_reg;
    assign results.sample_echo = echo_reg;
    assign results.last_code_a = st_a.code;
    assign results.last_code_b = st_b.code;
    assign results.shift_a     = st_a.shift;
    assign results.shift_b     = st_b.shift;
    assign results.frames_a    = st_a.count;
    assign results.frames_b    = st_b.count;

    `LBFD_ASSERT_IMPL(a_frames_a_on_latch, st_a.count != $past(st_a.count), st_a.shift == '0)
    `LBFD_ASSERT_IMPL(a_frames_b_on_latch, st_b.count != $past(st_b.count), st_b.shift == '0)
    `LBFD_ASSERT_IMPL(a_shift_only_on_step, st_a.shift != $past(st_a.shift), $past(adv))
    `LBFD_ASSERT_NEXT(a_result_after_step, adv, out_valid_reg)

endmodule

@@ verif/lbfd_decode_check.sv @@
// ----------------------------------------------------------------------------
// lbfd_decode_check
// Watches the sample, result and register channels of the decoder. Keeps its
// own copy of the band settings and of both channels, works out the result
// of every accepted sample and compares each accepted result with the oldest
// one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbfd_decode_check
    import lbfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    lbfd_sample_if  samples,
    lbfd_result_if  results,
    lbfd_cfg_if     cfg,
    output int      fail_count,
    output int      pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_echo;
        logic [SHIFT_W-1:0]  last_code_a;
        logic [SHIFT_W-1:0]  last_code_b;
        logic [SHIFT_W-1:0]  shift_a;
        logic [SHIFT_W-1:0]  shift_b;
        logic [COUNT_W-1:0]  frames_a;
        logic [COUNT_W-1:0]  frames_b;
    } decoded_t;

    cfg_t      bands;
    ch_state_t chan_a;
    ch_state_t chan_b;
    decoded_t  decoded_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // shift one bit in, or latch the frame once the limit is reached
    function automatic ch_state_t step_channel(input ch_state_t ch, input logic bit_in,
                                               input logic gated);
        ch_state_t nx = ch;
        if (ch.shift < bands.frame_limit)
        begin
            nx.shift = {ch.shift[SHIFT_W-2:0], bit_in};
        end
        else
        begin
            nx.code  = ch.shift;
            nx.shift = '0;
            if (!gated || ch.shift > bands.accept_limit)
                nx.count = ch.count + 1'b1;
        end
        return nx;
    endfunction

    // first matching band acts; a sample on a bound matches none
    function decoded_t decode_sample(input logic [SAMPLE_W-1:0] s);
        decoded_t r;
        if (s < bands.high_band_upper && s > bands.high_band_lower)
            chan_a = step_channel(chan_a, 1'b1, 1'b0);
        else if (s > bands.low_band_lower && s < bands.low_band_upper)
            chan_b = step_channel(chan_b, 1'b1, 1'b0);
        else if (s > bands.high_band_upper && chan_a.shift > 1)
            chan_a = step_channel(chan_a, 1'b0, 1'b0);
        else if (s < bands.low_band_lower && chan_b.shift > 1)
            chan_b = step_channel(chan_b, 1'b0, 1'b1);
        r.sample_echo = s;
        r.last_code_a = chan_a.code;
        r.last_code_b = chan_b.code;
        r.shift_a     = chan_a.shift;
        r.shift_b     = chan_b.shift;
        r.frames_a    = chan_a.count;
        r.frames_b    = chan_b.count;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_t want;
        if (!rst_n)
        begin
            bands = '{RST_HIGH_BAND_LOWER, RST_HIGH_BAND_UPPER, RST_LOW_BAND_LOWER,
                      RST_LOW_BAND_UPPER, RST_FRAME_LIMIT, RST_ACCEPT_LIMIT};
            chan_a = '0;
            chan_b = '0;
            decoded_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_HIGH_BAND_LOWER: bands.high_band_lower = cfg.data;
                    REG_HIGH_BAND_UPPER: bands.high_band_upper = cfg.data;
                    REG_LOW_BAND_LOWER:  bands.low_band_lower  = cfg.data;
                    REG_LOW_BAND_UPPER:  bands.low_band_upper  = cfg.data;
                    REG_FRAME_LIMIT:     bands.frame_limit     = cfg.data[SHIFT_W-1:0];
                    REG_ACCEPT_LIMIT:    bands.accept_limit    = cfg.data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            // results before samples: a sample cannot come out on its own edge
            if (results.valid && results.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result transaction with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("sample_echo", int'(want.sample_echo),
                                int'(results.sample_echo));
                    check_field("last_code_a", int'(want.last_code_a),
                                int'(results.last_code_a));
                    check_field("last_code_b", int'(want.last_code_b),
                                int'(results.last_code_b));
                    check_field("shift_a", int'(want.shift_a), int'(results.shift_a));
                    check_field("shift_b", int'(want.shift_b), int'(results.shift_b));
                    check_field("frames_a", int'(want.frames_a), int'(results.frames_a));
                    check_field("frames_b", int'(want.frames_b), int'(results.frames_b));
                end
            end
            if (samples.valid && samples.ready)
                decoded_q.push_back(decode_sample(samples.sample));
            pending = decoded_q.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the level band decoder with corner samples and then with runs of
// frame-building samples and noise under several band and limit settings,
// with random idle and stall patterns on both sides. Checking is done by
// lbfd_decode_check; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lbfd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int STALL_LIMIT    = 1000;
    localparam int ITEMS_PER_MODE = 38;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int NUM_SETTINGS   = 6;
    localparam logic [CIDX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
    localparam logic [CIDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;
    int items_sent   = 0;
    int settings_used = 0;
    int hb_lo, hb_hi, lb_lo, lb_hi;

    int tx_pct_by_mode [4] = '{0, 51, 0, 19};
    int rx_pct_by_mode [4] = '{0, 0, 51, 19};

    // bounds, values just inside the bands, and zero-band shifts at reset settings
    logic [SAMPLE_W-1:0] corner_samples [17] = '{
        12'd0, 12'd4095, 12'd3750, 12'd3850, 12'd150, 12'd250,
        12'd3751, 12'd4095, 12'd3849, 12'd4095, 12'd151, 12'd249,
        12'd0, 12'd149, 12'd2000, 12'd3850, 12'd150
    };

    lbfd_sample_if sample_ch ();
    lbfd_result_if result_ch ();
    lbfd_cfg_if    cfg_ch ();

    level_band_bit_frame_decoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    lbfd_decode_check u_decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (sample_ch),
        .results    (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #CLK_HALF clk = ~clk;

    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // all tasks start and end on a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid  = 1'b1;
        sample_ch.sample = s;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input int hl, input int hh, input int ll, input int lh,
                                  input int frame_lim, input int accept_lim);
        hb_lo = hl;
        hb_hi = hh;
        lb_lo = ll;
        lb_hi = lh;
        write_reg(REG_HIGH_BAND_LOWER, CDATA_W'(hl));
        write_reg(REG_HIGH_BAND_UPPER, CDATA_W'(hh));
        write_reg(REG_LOW_BAND_LOWER, CDATA_W'(ll));
        write_reg(REG_LOW_BAND_UPPER, CDATA_W'(lh));
        write_reg(REG_FRAME_LIMIT, CDATA_W'(frame_lim));
        write_reg(REG_ACCEPT_LIMIT, CDATA_W'(accept_lim));
        cfg_ch.valid = 1'b0;
        settings_used++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drained();
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // value strictly between two bounds; any value when the band is empty
    function automatic logic [SAMPLE_W-1:0] pick_band(input int lo_excl, input int hi_excl);
        if (hi_excl - lo_excl >= 2)
            return SAMPLE_W'($urandom_range(hi_excl - 1, lo_excl + 1));
        return SAMPLE_W'($urandom_range(4095, 0));
    endfunction

    // mostly frame runs on one channel (a leading one, then ones and zeros), some noise
    task automatic send_mix(input int n_items);
        int sent;
        int run_len;
        logic on_a;
        logic [SAMPLE_W-1:0] s;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 75)
            begin
                on_a    = 1'($urandom_range(1));
                run_len = $urandom_range(14, 2);
                for (int i = 0; i < run_len && sent < n_items; i++)
                begin
                    if (i == 0 || $urandom_range(99) < 55)
                        s = on_a ? pick_band(hb_lo, hb_hi) : pick_band(lb_lo, lb_hi);
                    else
                        s = on_a ? pick_band(hb_hi, 4096) : pick_band(-1, lb_lo);
                    send_sample(s);
                    sent++;
                end
            end
            else
            begin
                case ($urandom_range(3))
                    0: s = SAMPLE_W'($urandom_range(4095, 0));
                    1: s = ($urandom_range(1) != 0) ? 12'd4095 : 12'd0;
                    2: s = ($urandom_range(1) != 0) ? pick_band(lb_hi, hb_lo)
                                                   : pick_band(-1, 4096);
                    default:
                        case ($urandom_range(3))
                            0: s = SAMPLE_W'(hb_lo);
                            1: s = SAMPLE_W'(hb_hi);
                            2: s = SAMPLE_W'(lb_lo);
                            default: s = SAMPLE_W'(lb_hi);
                        endcase
                endcase
                send_sample(s);
                sent++;
            end
        end
    endtask

    initial
    begin
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_HIGH_BAND_LOWER;
        cfg_ch.data      = '0;
        hb_lo = int'(RST_HIGH_BAND_LOWER);
        hb_hi = int'(RST_HIGH_BAND_UPPER);
        lb_lo = int'(RST_LOW_BAND_LOWER);
        lb_hi = int'(RST_LOW_BAND_UPPER);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unmapped indexes must leave the reset settings alone
        write_reg(UNMAPPED_IDX_LO, CDATA_W'($urandom_range(4095, 0)));
        write_reg(UNMAPPED_IDX_HI, CDATA_W'($urandom_range(4095, 0)));
        cfg_ch.valid = 1'b0;

        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        for (int phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            wait_drained();
            case (phase)
                0: apply_settings(3000, 3400, 500, 900, 8, 11);
                // overlapping full-range bands, priority to A; smallest limit
                1: apply_settings(0, 4095, 0, 4095, 1, 0);
                // limit of zero: every qualifying sample latches
                2: apply_settings(3750, 3850, 150, 250, 0, 1023);
                // limit above 512 lets the shift wrap
                3: apply_settings(2048, 4000, 100, 2047, 1023, 512);
                // inverted A bounds: A only drains leftovers through its zero band
                4: apply_settings(4095, 0, 100, 4095, 16, 1023);
                default: apply_settings($urandom_range(4095, 0), $urandom_range(4095, 0),
                                        $urandom_range(4095, 0), $urandom_range(4095, 0),
                                        $urandom_range(40, 1), $urandom_range(40, 0));
            endcase
            for (int mode = 0; mode < 4; mode++)
            begin
                tx_idle_pct  = tx_pct_by_mode[mode];
                rx_stall_pct = rx_pct_by_mode[mode];
                send_mix(ITEMS_PER_MODE);
                wait_drained();
            end
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d samples over %0d band/limit settings plus reset defaults,", items_sent,
                 settings_used);
        $display("tb: four flow-control mixes each, incl. empty bands and limits 0, 1, 1023");
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lbfd_pkg.sv
src/lbfd_if.sv
src/lbfd_cfg_regs.sv
src/lbfd_band_decode.sv
src/lbfd_channel.sv
src/level_band_bit_frame_decoder_unit.sv
verif/lbfd_decode_check.sv
verif/tb_top.sv
